FILE: rtl/core/ttb_pkg.sv
package ttb_pkg;

    localparam int CHAR_W  = 8;
    localparam int BITS_W  = 12;
    localparam int COUNT_W = 4;
    localparam int DIGIT_W = 6;
    localparam int MODE_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_AUTO = 2'd0,
        MODE_HEX  = 2'd1,
        MODE_BIN  = 2'd2,
        MODE_B64  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_ZERO   = 3'd1,
        PH_AFTERX = 3'd2,
        PH_ZEROX  = 3'd3,
        PH_HEX    = 3'd4,
        PH_BIN    = 3'd5,
        PH_HALT   = 3'd6,
        PH_PAD    = 3'd7
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [DIGIT_W-1:0] held_digit;
        logic               held_valid;
        logic [1:0]         run_pos;
    } ttb_state_t;

    typedef struct packed {
        logic [BITS_W-1:0]  bits;
        logic [COUNT_W-1:0] count;
        logic               done;
        logic               halted;
    } ttb_result_t;

    localparam ttb_state_t STATE_RESET = '{
        phase:      PH_START,
        held_digit: '0,
        held_valid: 1'b0,
        run_pos:    2'd0
    };

endpackage

FILE: rtl/core/text_to_bitstream_decoder.sv
// text to bitstream decoder: hex, binary and base64 text in, raw bits out
//
// input channel s_*: one text character per word, s_tlast marks the final
// character of a text. output channel m_*: one result word per character,
// carrying the bits that character releases, right-aligned, first bit msb.
// cfg_wr_en/cfg_wr_data write the two-bit text mode (auto, hex, binary,
// base64); a write also restarts the text. write it only while idle.
//
// throughput is one character per cycle while m_tready takes the results.
// an accepted character is held in the input register, then the decode
// logic and the parse state update load the result register, which drives
// m_tvalid.
//
// reset clears the mode to auto, the parse state to token start and both
// valid flags. when m_tready is low the result is held and one more word is
// taken into the input register; after that s_tready drops until the result
// is taken.
module text_to_bitstream_decoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,     // text_char
    input  logic                             s_tlast,     // end_of_text
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,     // out_bits[11:0], out_count[15:12]
    output logic                             m_tlast,     // text_done
    output logic                             m_tuser,     // halted
    input  logic                             cfg_wr_en,
    input  logic [ttb_pkg::MODE_W-1:0]       cfg_wr_data
);

    ttb_pkg::mode_t       mode_reg;
    ttb_pkg::mode_t       mode_next;
    ttb_pkg::ttb_state_t  state_reg;
    ttb_pkg::ttb_state_t  state_next;
    ttb_pkg::ttb_state_t  dec_state;
    ttb_pkg::ttb_result_t dec_res;
    ttb_pkg::ttb_result_t res_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic                       in_valid;
    logic [ttb_pkg::CHAR_W-1:0] in_char;
    logic                       in_last;
    logic                       advance;

    assign advance = in_valid && (!out_valid_reg || m_tready);

    ttb_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_char   (s_tdata),
        .s_last   (s_tlast),
        .advance  (advance),
        .in_valid (in_valid),
        .in_char  (in_char),
        .in_last  (in_last)
    );

    ttb_decode u_decode (
        .mode    (mode_reg),
        .cur     (state_reg),
        .in_char (in_char),
        .in_last (in_last),
        .nxt     (dec_state),
        .res     (dec_res)
    );

    always_comb
    begin
        mode_next      = mode_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (cfg_wr_en)
        begin
            mode_next  = ttb_pkg::mode_t'(cfg_wr_data);
            state_next = ttb_pkg::STATE_RESET;
        end
        else if (advance)
        begin
            state_next = dec_state;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= ttb_pkg::MODE_AUTO;
            state_reg     <= ttb_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= dec_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.count, res_reg.bits};
    assign m_tlast  = res_reg.done;
    assign m_tuser  = res_reg.halted;

endmodule

FILE: rtl/core/ttb_in_stage.sv
module ttb_in_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ttb_pkg::CHAR_W-1:0] s_char,
    input  logic                       s_last,
    input  logic                       advance,
    output logic                       in_valid,
    output logic [ttb_pkg::CHAR_W-1:0] in_char,
    output logic                       in_last
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [ttb_pkg::CHAR_W-1:0] char_reg;
    logic                       last_reg;
    logic                       accept;

    assign s_tready = !valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= s_char;
            last_reg <= s_last;
        end
    end

    assign in_valid = valid_reg;
    assign in_char  = char_reg;
    assign in_last  = last_reg;

endmodule

FILE: rtl/core/ttb_decode.sv
module ttb_decode (
    input  ttb_pkg::mode_t             mode,
    input  ttb_pkg::ttb_state_t        cur,
    input  logic [ttb_pkg::CHAR_W-1:0] in_char,
    input  logic                       in_last,
    output ttb_pkg::ttb_state_t        nxt,
    output ttb_pkg::ttb_result_t       res
);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    function automatic logic [6:0] b64_val(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = {1'b1, 6'(c - 8'h41)};
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = {1'b1, 6'(c - 8'h47)};
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 6'(c + 8'h04)};
        end
        else if (c == 8'h2B)
        begin
            r = {1'b1, 6'd62};
        end
        else if (c == 8'h2F)
        begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

    function automatic logic [ttb_pkg::BITS_W-1:0] shift_in(
        input logic [ttb_pkg::BITS_W-1:0]  a,
        input logic [ttb_pkg::DIGIT_W-1:0] v,
        input logic [2:0]                  n
    );
        logic [ttb_pkg::DIGIT_W-1:0] m;
        m = (ttb_pkg::DIGIT_W'(1) << n) - ttb_pkg::DIGIT_W'(1);
        return (a << n) | {{(ttb_pkg::BITS_W-ttb_pkg::DIGIT_W){1'b0}}, v & m};
    endfunction

    logic [ttb_pkg::BITS_W-1:0]  acc;
    logic [ttb_pkg::COUNT_W-1:0] cnt;
    logic [4:0]                  hv;
    logic [6:0]                  bv;
    logic                        ws;
    logic                        hex_path;
    logic                        rel_zero;
    logic                        bin_put;
    logic [2:0]                  fl_n;
    logic [2:0]                  fl_sh;

    always_comb
    begin
        acc      = '0;
        cnt      = '0;
        nxt      = cur;
        hv       = hex_val(in_char);
        bv       = b64_val(in_char);
        ws       = (in_char == CH_SPACE) || (in_char >= CH_TAB && in_char <= CH_CR);
        hex_path = 1'b0;
        rel_zero = 1'b0;
        bin_put  = 1'b0;
        fl_n     = 3'd0;
        fl_sh    = 3'd0;

        case (mode)
            ttb_pkg::MODE_AUTO:
            begin
                case (cur.phase)
                    ttb_pkg::PH_START:
                    begin
                        if (in_char == CH_ZERO)
                            nxt.phase = ttb_pkg::PH_ZERO;
                        else
                            hex_path = 1'b1;
                    end
                    ttb_pkg::PH_ZERO:
                    begin
                        if (in_char == CH_LO_B || in_char == CH_UP_B)
                            nxt.phase = ttb_pkg::PH_BIN;
                        else if (in_char == CH_LO_X)
                            nxt.phase = ttb_pkg::PH_AFTERX;
                        else if (in_char == CH_UP_X)
                            nxt.phase = ttb_pkg::PH_HEX;
                        else
                        begin
                            rel_zero = 1'b1;
                            hex_path = 1'b1;
                        end
                    end
                    ttb_pkg::PH_AFTERX:
                    begin
                        if (in_char == CH_ZERO)
                            nxt.phase = ttb_pkg::PH_ZEROX;
                        else
                            hex_path = 1'b1;
                    end
                    ttb_pkg::PH_ZEROX:
                    begin
                        if (in_char == CH_UP_X)
                            nxt.phase = ttb_pkg::PH_HEX;
                        else
                        begin
                            rel_zero = 1'b1;
                            hex_path = 1'b1;
                        end
                    end
                    ttb_pkg::PH_HEX:
                    begin
                        hex_path = 1'b1;
                    end
                    ttb_pkg::PH_BIN:
                    begin
                        if (in_char == CH_ZERO || in_char == CH_ONE)
                            bin_put = 1'b1;
                        else
                            hex_path = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase

                if (rel_zero)
                begin
                    acc = shift_in(acc, '0, 3'd4);
                    cnt = cnt + 4'd4;
                end
                if (bin_put)
                begin
                    acc = shift_in(acc, {5'd0, in_char[0]}, 3'd1);
                    cnt = cnt + 4'd1;
                end
                if (hex_path)
                begin
                    if (hv[4])
                    begin
                        acc       = shift_in(acc, {2'd0, hv[3:0]}, 3'd4);
                        cnt       = cnt + 4'd4;
                        nxt.phase = ttb_pkg::PH_HEX;
                    end
                    else if (ws)
                        nxt.phase = ttb_pkg::PH_START;
                    else
                        nxt.phase = ttb_pkg::PH_HALT;
                end
                if (in_last && (nxt.phase == ttb_pkg::PH_ZERO ||
                                nxt.phase == ttb_pkg::PH_ZEROX))
                begin
                    acc = shift_in(acc, '0, 3'd4);
                    cnt = cnt + 4'd4;
                end
            end
            ttb_pkg::MODE_HEX:
            begin
                if (cur.phase != ttb_pkg::PH_HALT)
                begin
                    if (hv[4])
                    begin
                        acc = shift_in(acc, {2'd0, hv[3:0]}, 3'd4);
                        cnt = cnt + 4'd4;
                    end
                    else
                        nxt.phase = ttb_pkg::PH_HALT;
                end
            end
            ttb_pkg::MODE_BIN:
            begin
                if (cur.phase != ttb_pkg::PH_HALT)
                begin
                    if (in_char == CH_ZERO || in_char == CH_ONE)
                    begin
                        acc = shift_in(acc, {5'd0, in_char[0]}, 3'd1);
                        cnt = cnt + 4'd1;
                    end
                    else
                        nxt.phase = ttb_pkg::PH_HALT;
                end
            end
            ttb_pkg::MODE_B64:
            begin
                if (cur.phase == ttb_pkg::PH_PAD)
                begin
                    if (in_char != CH_PAD)
                        nxt.phase = ttb_pkg::PH_HALT;
                end
                else if (cur.phase != ttb_pkg::PH_HALT)
                begin
                    if (bv[6])
                    begin
                        if (cur.held_valid)
                        begin
                            acc         = shift_in(acc, cur.held_digit, 3'd6);
                            cnt         = cnt + 4'd6;
                            nxt.run_pos = cur.run_pos + 2'd1;
                        end
                        else
                            nxt.run_pos = 2'd0;
                        nxt.held_digit = bv[5:0];
                        nxt.held_valid = 1'b1;
                    end
                    else
                    begin
                        if (nxt.held_valid)
                        begin
                            fl_n  = {nxt.run_pos, 1'b0};
                            fl_sh = 3'd6 - fl_n;
                            acc   = shift_in(acc, nxt.held_digit >> fl_sh, fl_n);
                            cnt   = cnt + {1'b0, fl_n};
                            nxt.held_valid = 1'b0;
                        end
                        nxt.phase = (in_char == CH_PAD) ? ttb_pkg::PH_PAD
                                                        : ttb_pkg::PH_HALT;
                    end
                end
                if (in_last && nxt.held_valid)
                begin
                    fl_n  = {nxt.run_pos, 1'b0};
                    fl_sh = 3'd6 - fl_n;
                    acc   = shift_in(acc, nxt.held_digit >> fl_sh, fl_n);
                    cnt   = cnt + {1'b0, fl_n};
                    nxt.held_valid = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        res.bits   = acc;
        res.count  = cnt;
        res.done   = in_last;
        res.halted = (nxt.phase == ttb_pkg::PH_HALT);

        if (in_last)
        begin
            nxt = ttb_pkg::STATE_RESET;
        end
    end

endmodule

FILE: rtl/core/ttb_checker.sv
module ttb_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [15:0]                m_tdata,
    input logic                       m_tlast,
    input logic                       m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:12] <= 4'd12)
        else $error("bit count above twelve");

    // no bits beyond the count, for counts of zero and one
    a_bits_fit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[15:12] == 4'd0 || m_tdata[15:12] == 4'd1)
            |-> (m_tdata[11:1] == 11'd0)
            && (m_tdata[15:12] == 4'd1 || !m_tdata[0]))
        else $error("bits set outside count");

    // odd counts only come from a single binary digit
    a_odd_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[12] |-> m_tdata[15:12] == 4'd1)
        else $error("odd bit count other than one");

    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid out of reset");

endmodule

bind text_to_bitstream_decoder ttb_checker u_ttb_checker (.*);

FILE: tb/sv/text_to_bitstream_decoder_test.sv
module text_to_bitstream_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ttb_pkg::*;

    localparam int TARGET_CHARS  = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 10;
    localparam int STUCK_LIMIT   = 4000;

    typedef logic [CHAR_W-1:0] text_q_t [$];

    typedef struct {
        mode_t             mode;
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              pin;
        ttb_result_t       want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_wr_en;
    logic [MODE_W-1:0]    cfg_wr_data;

    // decoder model state
    mode_t                cur_mode;
    phase_t               phase;
    logic [DIGIT_W-1:0]   held_digit;
    logic                 held_valid;
    logic [1:0]           run_pos;
    logic [BITS_W-1:0]    acc_bits;
    logic [COUNT_W-1:0]   acc_count;

    ttb_result_t          pending_results [$];
    logic                 row_pinned;
    ttb_result_t          row_want;

    mode_t                mode_now;
    bit                   steady;
    int                   burst_left;
    bit                   hold_off_req;
    int                   hold_offs;
    int                   stuck_cycles;
    int                   mismatches;
    int                   chars_sent;
    int                   chars_taken;
    int                   results_checked;
    int                   texts_sent;
    int                   halted_seen;
    int                   mode_writes;

    // directed words: pinned rows carry a hand-derived result
    stim_row_t directed_rows [25] = '{
        '{MODE_AUTO, "0",   1'b1, 1'b1, '{12'h000, 4'd0 + 4'd4, 1'b1, 1'b0}},
        '{MODE_AUTO, "0",   1'b0, 1'b0, '0},
        '{MODE_AUTO, "B",   1'b0, 1'b0, '0},
        '{MODE_AUTO, "1",   1'b0, 1'b0, '0},
        '{MODE_AUTO, "7",   1'b0, 1'b0, '0},
        '{MODE_AUTO, " ",   1'b0, 1'b0, '0},
        '{MODE_AUTO, "0",   1'b0, 1'b0, '0},
        '{MODE_AUTO, "x",   1'b0, 1'b0, '0},
        '{MODE_AUTO, "0",   1'b0, 1'b0, '0},
        '{MODE_AUTO, "X",   1'b0, 1'b0, '0},
        '{MODE_AUTO, "f",   1'b0, 1'b0, '0},
        '{MODE_AUTO, "g",   1'b0, 1'b1, '{12'h000, 4'd0, 1'b0, 1'b1}},
        '{MODE_AUTO, 8'hFF, 1'b1, 1'b1, '{12'h000, 4'd0, 1'b1, 1'b1}},
        '{MODE_HEX,  "a",   1'b0, 1'b0, '0},
        '{MODE_HEX,  8'h00, 1'b0, 1'b1, '{12'h000, 4'd0, 1'b0, 1'b1}},
        '{MODE_BIN,  "1",   1'b0, 1'b0, '0},
        '{MODE_BIN,  "2",   1'b1, 1'b1, '{12'h000, 4'd0, 1'b1, 1'b1}},
        '{MODE_B64,  "/",   1'b0, 1'b0, '0},
        '{MODE_B64,  "A",   1'b0, 1'b0, '0},
        '{MODE_B64,  "+",   1'b0, 1'b0, '0},
        '{MODE_B64,  "z",   1'b1, 1'b1, '{12'hFB3, 4'd12, 1'b1, 1'b0}},
        '{MODE_B64,  "Q",   1'b0, 1'b0, '0},
        '{MODE_B64,  "=",   1'b0, 1'b0, '0},
        '{MODE_B64,  "=",   1'b0, 1'b0, '0},
        '{MODE_B64,  "9",   1'b1, 1'b1, '{12'h000, 4'd0, 1'b1, 1'b1}}
    };

    text_to_bitstream_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void restart_text();
        phase      = PH_START;
        held_digit = '0;
        held_valid = 1'b0;
        run_pos    = 2'd0;
    endfunction

    function automatic void emit(input logic [BITS_W-1:0] value, input int n);
        logic [BITS_W-1:0] mask;
        mask      = (12'd1 << n) - 12'd1;
        acc_bits  = (acc_bits << n) | (value & mask);
        acc_count = acc_count + COUNT_W'(n);
    endfunction

    function automatic int hex_digit(input logic [CHAR_W-1:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        return -1;
    endfunction

    // character inside or opening a hex token
    function automatic void auto_hex(input logic [CHAR_W-1:0] c);
        int v;
        v = hex_digit(c);
        if (v >= 0)
        begin
            emit(BITS_W'(v), 4);
            phase = PH_HEX;
        end
        else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
            phase = PH_START;
        else
            phase = PH_HALT;
    endfunction

    // release the held base64 digit, trimmed to whole bytes
    function automatic void b64_release();
        int n;
        if (held_valid)
        begin
            n = int'(run_pos) * 2;
            emit(BITS_W'(held_digit >> (6 - n)), n);
            held_valid = 1'b0;
        end
    endfunction

    function automatic ttb_result_t decode_char(input logic [CHAR_W-1:0] c, input logic last);
        ttb_result_t r;
        int          v;
        acc_bits  = '0;
        acc_count = '0;
        case (cur_mode)
            MODE_AUTO:
            begin
                case (phase)
                    PH_START:
                        if (c == "0")
                            phase = PH_ZERO;
                        else
                            auto_hex(c);
                    PH_ZERO:
                        if (c == "b" || c == "B")
                            phase = PH_BIN;
                        else if (c == "x")
                            phase = PH_AFTERX;
                        else if (c == "X")
                            phase = PH_HEX;
                        else
                        begin
                            emit('0, 4);
                            auto_hex(c);
                        end
                    PH_AFTERX:
                        if (c == "0")
                            phase = PH_ZEROX;
                        else
                            auto_hex(c);
                    PH_ZEROX:
                        if (c == "X")
                            phase = PH_HEX;
                        else
                        begin
                            emit('0, 4);
                            auto_hex(c);
                        end
                    PH_HEX:
                        auto_hex(c);
                    PH_BIN:
                        if (c == "0" || c == "1")
                            emit(BITS_W'(c[0]), 1);
                        else
                            auto_hex(c);
                    default:
                    begin
                    end
                endcase
                if (last && (phase == PH_ZERO || phase == PH_ZEROX))
                    emit('0, 4);
            end
            MODE_HEX:
                if (phase != PH_HALT)
                begin
                    v = hex_digit(c);
                    if (v >= 0)
                        emit(BITS_W'(v), 4);
                    else
                        phase = PH_HALT;
                end
            MODE_BIN:
                if (phase != PH_HALT)
                begin
                    if (c == "0" || c == "1")
                        emit(BITS_W'(c[0]), 1);
                    else
                        phase = PH_HALT;
                end
            default:
            begin
                if (phase == PH_PAD)
                begin
                    if (c != "=")
                        phase = PH_HALT;
                end
                else if (phase != PH_HALT)
                begin
                    if (c >= "A" && c <= "Z")
                        v = int'(c - "A");
                    else if (c >= "a" && c <= "z")
                        v = int'(c - "a") + 26;
                    else if (c >= "0" && c <= "9")
                        v = int'(c - "0") + 52;
                    else if (c == "+")
                        v = 62;
                    else if (c == "/")
                        v = 63;
                    else
                        v = -1;
                    if (v >= 0)
                    begin
                        if (held_valid)
                        begin
                            emit(BITS_W'(held_digit), 6);
                            run_pos = run_pos + 2'd1;
                        end
                        else
                            run_pos = 2'd0;
                        held_digit = v[DIGIT_W-1:0];
                        held_valid = 1'b1;
                    end
                    else
                    begin
                        b64_release();
                        if (c == "=")
                            phase = PH_PAD;
                        else
                            phase = PH_HALT;
                    end
                end
                if (last)
                    b64_release();
            end
        endcase
        r.bits   = acc_bits;
        r.count  = acc_count;
        r.done   = last;
        r.halted = (phase == PH_HALT);
        if (last)
            restart_text();
        return r;
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // check results and predict each accepted character
    always @(posedge clk)
    begin
        ttb_result_t got;
        ttb_result_t want;
        if (!rst_n)
        begin
            cur_mode = MODE_AUTO;
            restart_text();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cur_mode = mode_t'(cfg_wr_data);
                restart_text();
            end
            if (m_tvalid && m_tready)
            begin
                got.bits   = m_tdata[11:0];
                got.count  = m_tdata[15:12];
                got.done   = m_tlast;
                got.halted = m_tuser;
                if (got.halted === 1'b1)
                    halted_seen++;
                if (pending_results.size() == 0)
                    flag_mismatch($sformatf("unexpected word bits %h count %0d", got.bits,
                        got.count));
                else
                begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (got.bits !== want.bits || got.count !== want.count ||
                        got.done !== want.done || got.halted !== want.halted)
                        flag_mismatch($sformatf(
                            "expected bits %h count %0d done %b halted %b, got %h %0d %b %b",
                            want.bits, want.count, want.done, want.halted,
                            got.bits, got.count, got.done, got.halted));
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = decode_char(s_tdata, s_tlast);
                if (row_pinned)
                    want = row_want;
                pending_results.push_back(want);
                chars_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
            stuck_cycles++;
        else
            stuck_cycles = 0;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
            $display("text_to_bitstream_decoder test failed");
            $finish;
        end
    end

    // sink side: changing stall patterns plus one long hold-off on request
    initial
    begin
        int pattern_left;
        int stall_style;
        int cycle_no;
        m_tready     = 1'b0;
        pattern_left = 0;
        stall_style  = 0;
        cycle_no     = 0;
        forever
        begin
            @(negedge clk);
            cycle_no++;
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
                hold_offs++;
            end
            if (pattern_left == 0)
            begin
                stall_style  = $urandom_range(0, 3);
                pattern_left = $urandom_range(16, 96);
            end
            pattern_left--;
            case (stall_style)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (cycle_no % 4 != 3);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic offer_char(input logic [CHAR_W-1:0] c, input logic last, input logic pin,
                              input ttb_result_t pinned_res);
        if (!steady && burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        s_tdata    <= c;
        s_tlast    <= last;
        s_tvalid   <= 1'b1;
        row_pinned <= pin;
        row_want   <= pinned_res;
        chars_sent++;
        if (last)
            texts_sent++;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_mode(input mode_t m);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_data <= m;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        mode_now = m;
        mode_writes++;
    endtask

    function automatic text_q_t compose_text(input mode_t m);
        text_q_t t;
        string   hex_set;
        string   b64_set;
        int      n;
        int      kind;
        logic [7:0] ws;
        hex_set = "0123456789ABCDEFabcdef";
        b64_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n) t.push_back(CHAR_W'($urandom_range(0, 255)));
            return t;
        end
        case (m)
            MODE_AUTO:
            begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                begin
                    if (k > 0 || $urandom_range(0, 7) == 0)
                        repeat ($urandom_range(1, 2))
                        begin
                            ws = 8'($urandom_range(8, 13));
                            t.push_back(ws == 8 ? 8'h20 : ws);
                        end
                    kind = $urandom_range(0, 4);
                    case (kind)
                        0:
                            repeat ($urandom_range(1, 5))
                                t.push_back(hex_set[$urandom_range(0, 21)]);
                        1:
                        begin
                            t.push_back("0");
                            t.push_back($urandom_range(0, 1) ? "x" : "X");
                            if ($urandom_range(0, 2) == 0)
                            begin
                                t.push_back("0");
                                t.push_back("X");
                            end
                            repeat ($urandom_range(0, 4))
                                t.push_back(hex_set[$urandom_range(0, 21)]);
                        end
                        2:
                        begin
                            t.push_back("0");
                            t.push_back($urandom_range(0, 1) ? "b" : "B");
                            repeat ($urandom_range(1, 8))
                                t.push_back($urandom_range(0, 1) ? "1" : "0");
                            if ($urandom_range(0, 2) == 0)
                                repeat ($urandom_range(1, 3))
                                    t.push_back(hex_set[$urandom_range(0, 21)]);
                        end
                        3:
                        begin
                            t.push_back("0");
                            repeat ($urandom_range(0, 2))
                                t.push_back(hex_set[$urandom_range(0, 21)]);
                        end
                        default:
                        begin
                            t.push_back("0");
                            t.push_back("x");
                            t.push_back("0");
                        end
                    endcase
                end
            end
            MODE_HEX:
                repeat ($urandom_range(1, 8))
                    t.push_back(hex_set[$urandom_range(0, 21)]);
            MODE_BIN:
                repeat ($urandom_range(1, 12))
                    t.push_back($urandom_range(0, 1) ? "1" : "0");
            default:
            begin
                repeat ($urandom_range(1, 10))
                    t.push_back(b64_set[$urandom_range(0, 63)]);
                repeat ($urandom_range(0, 2))
                    t.push_back("=");
                if ($urandom_range(0, 6) == 0)
                    t.push_back(b64_set[$urandom_range(0, 63)]);
            end
        endcase
        if ($urandom_range(0, 9) == 0)
            t[$urandom_range(0, t.size() - 1)] = CHAR_W'($urandom_range(0, 255));
        return t;
    endfunction

    initial
    begin
        text_q_t txt;
        mode_t   m;
        int      phase_no;
        int      texts;
        bit      cut;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = MODE_AUTO;
        row_pinned   = 1'b0;
        row_want     = '0;
        mode_now     = MODE_AUTO;
        steady       = 1'b1;
        burst_left   = 0;
        hold_off_req = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].mode != mode_now)
                set_mode(directed_rows[i].mode);
            offer_char(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].pin,
                       directed_rows[i].want);
        end

        phase_no = 0;
        while (chars_sent < TARGET_CHARS)
        begin
            m = (phase_no < 4) ? mode_t'(phase_no) : mode_t'($urandom_range(0, 3));
            set_mode(m);
            steady = ($urandom_range(0, 3) == 0);
            if (phase_no == 2)
            begin
                steady       = 1'b1;
                hold_off_req = 1'b1;
            end
            texts = $urandom_range(8, 20);
            for (int k = 0; k < texts; k++)
            begin
                txt = compose_text(m);
                // sometimes leave a text open so the next mode write restarts it
                cut = (k == texts - 1) && ($urandom_range(0, 3) == 0);
                foreach (txt[i])
                    offer_char(txt[i], (i == txt.size() - 1) && !cut, 1'b0, '0);
            end
            phase_no++;
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (pending_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        $display("run: %0d characters in %0d texts, %0d results checked, %0d mismatches",
                 chars_taken, texts_sent, results_checked, mismatches);
        $display("run: %0d mode writes, %0d halted results, %0d long sink hold-offs",
                 mode_writes, halted_seen, hold_offs);
        if (mismatches == 0)
            $display("text_to_bitstream_decoder test passed");
        else
            $display("text_to_bitstream_decoder test failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/ttb_pkg.sv
rtl/core/ttb_in_stage.sv
rtl/core/ttb_decode.sv
rtl/core/text_to_bitstream_decoder.sv
rtl/core/ttb_checker.sv
tb/sv/text_to_bitstream_decoder_test.sv
